// ----- hdl/lattice_path_counter_top_defines.svh -----
// ----------------------------------------------------------------------------
// lattice_path_counter_top_defines.svh
// Assertion macros used by the lattice path counter RTL.
// ----------------------------------------------------------------------------
`ifndef LATTICE_PATH_COUNTER_TOP_DEFINES_SVH
`define LATTICE_PATH_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define LPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg
// Types and constants of the lattice path counter.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Coordinate and count widths.
  localparam int COORD_W   = 4;
  localparam int COUNT_W   = 36;
  // One row buffer entry per possible column offset.
  localparam int ROW_DEPTH = 1 << COORD_W;
  // Width that holds any grid size bound (up to 256).
  localparam int GRID_LIM_W = 9;

  // Default grid size.
  localparam int GRID_ROWS_DEF = 16;
  localparam int GRID_COLS_DEF = 16;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_RUN,
    ST_FIN
  } state_t;

endpackage

// ----- hdl/lpc_ram.sv -----
// ----------------------------------------------------------------------------
// lpc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lattice_path_counter_top.sv -----
// ----------------------------------------------------------------------------
// lattice_path_counter_top
// Counts right / down / diagonal lattice paths from an entry cell to an exit
// cell (a Delannoy number), one row of the count table at a time through a
// row buffer RAM.
//
//   channel | direction | words
//   --------+-----------+--------------------------------------------------
//   in_     | input     | start_row, start_col, end_row, end_col (4 b each)
//   out_    | output    | path_count (36 b), one word per input word
//
// Trivial queries (no path, or a straight line) go from accept straight to
// the finish state; others first fill row zero of the row buffer RAM, then
// sweep rows one to dr over columns zero to dc, with dr, dc the row and
// column offsets, one cell updated per cycle. Reset (rst_n, synchronous) returns
// to idle with no result pending; the RAM needs no clearing. A stalled
// result holds in the output register; the next word is taken only after
// the current query has handed its result to that register.
// ----------------------------------------------------------------------------
`include "lattice_path_counter_top_defines.svh"

module lattice_path_counter_top
  import lpc_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  coord_t       in_start_row,
  input  coord_t       in_start_col,
  input  coord_t       in_end_row,
  input  coord_t       in_end_col,
  output logic         out_valid,
  input  logic         out_ready,
  output count_t       out_path_count
);

  localparam logic [GRID_LIM_W-1:0] ROW_LIM   = GRID_LIM_W'(GRID_ROWS);
  localparam logic [GRID_LIM_W-1:0] COL_LIM   = GRID_LIM_W'(GRID_COLS);
  localparam count_t                COUNT_ONE = COUNT_W'(1);

  // Control registers.
  state_t state_r, state_nxt;
  logic   issuing_r, issuing_nxt;
  logic   vld1_r, vld1_nxt;
  logic   last1_r, last1_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Payload registers.
  coord_t dr_r, dr_nxt;
  coord_t dc_r, dc_nxt;
  coord_t row_r, row_nxt;
  coord_t col_r, col_nxt;
  coord_t col1_r, col1_nxt;
  count_t left_r, left_nxt;
  count_t diag_r, diag_nxt;
  count_t count_r, count_nxt;
  count_t out_count_r, out_count_nxt;

  // RAM port.
  logic   ram_we;
  coord_t ram_waddr;
  count_t ram_wdata;
  count_t ram_rdata;

  logic   in_fire;
  logic   out_free;
  logic   in_grid;
  logic   path_ok;
  logic   deep_case;
  coord_t in_dr;
  coord_t in_dc;
  count_t cell_sum;

  // Handshake.
  assign in_ready       = (state_r == ST_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_path_count = out_count_r;
  assign out_free       = !out_valid_r || out_ready;

  // Classify the query.
  assign in_grid   = ({{(GRID_LIM_W-COORD_W){1'b0}}, in_start_row} < ROW_LIM) &&
                     ({{(GRID_LIM_W-COORD_W){1'b0}}, in_end_row}   < ROW_LIM) &&
                     ({{(GRID_LIM_W-COORD_W){1'b0}}, in_start_col} < COL_LIM) &&
                     ({{(GRID_LIM_W-COORD_W){1'b0}}, in_end_col}   < COL_LIM);
  assign path_ok   = in_grid && (in_start_row <= in_end_row) &&
                     (in_start_col <= in_end_col) &&
                     !((in_start_row == in_end_row) && (in_start_col == in_end_col));
  assign in_dr     = in_end_row - in_start_row;
  assign in_dc     = in_end_col - in_start_col;
  assign deep_case = path_ok && (in_dr != '0) && (in_dc != '0);

  // New cell: up + left + diagonal, first column is always one.
  assign cell_sum = (col1_r == '0) ? COUNT_ONE : COUNT_W'(ram_rdata + left_r + diag_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) begin
        state_nxt = deep_case ? ST_INIT : ST_FIN;
      end
      ST_INIT: if (col_r == dc_r) begin
        state_nxt = ST_RUN;
      end
      ST_RUN: if (vld1_r && last1_r) begin
        state_nxt = ST_FIN;
      end
      ST_FIN: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    issuing_nxt   = issuing_r;
    vld1_nxt      = 1'b0;
    last1_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    dr_nxt        = dr_r;
    dc_nxt        = dc_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    col1_nxt      = col1_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    count_nxt     = count_r;
    out_count_nxt = out_count_r;
    ram_we        = 1'b0;
    ram_waddr     = col_r;
    ram_wdata     = COUNT_ONE;
    unique case (state_r)
      ST_IDLE: begin
        // Latch offsets; trivial answers go straight to the result.
        if (in_fire) begin
          dr_nxt    = in_dr;
          dc_nxt    = in_dc;
          col_nxt   = '0;
          count_nxt = path_ok ? COUNT_ONE : '0;
        end
      end
      ST_INIT: begin
        // Fill row zero of the table with ones.
        ram_we = 1'b1;
        if (col_r == dc_r) begin
          col_nxt     = '0;
          row_nxt     = COORD_W'(1);
          issuing_nxt = 1'b1;
        end else begin
          col_nxt = col_r + COORD_W'(1);
        end
      end
      ST_RUN: begin
        // Issue the read of the cell above.
        vld1_nxt  = issuing_r;
        col1_nxt  = col_r;
        last1_nxt = issuing_r && (col_r == dc_r) && (row_r == dr_r);
        if (issuing_r) begin
          if (col_r == dc_r) begin
            col_nxt = '0;
            row_nxt = row_r + COORD_W'(1);
            if (row_r == dr_r) begin
              issuing_nxt = 1'b0;
            end
          end else begin
            col_nxt = col_r + COORD_W'(1);
          end
        end
        // Complete the cell and write it back over the one above.
        if (vld1_r) begin
          ram_we    = 1'b1;
          ram_waddr = col1_r;
          ram_wdata = cell_sum;
          left_nxt  = cell_sum;
          diag_nxt  = ram_rdata;
          if (last1_r) begin
            count_nxt = cell_sum;
          end
        end
      end
      ST_FIN: begin
        // Hand the count to the output register.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issuing_r   <= 1'b0;
      vld1_r      <= 1'b0;
      last1_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issuing_r   <= issuing_nxt;
      vld1_r      <= vld1_nxt;
      last1_r     <= last1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    dr_r        <= dr_nxt;
    dc_r        <= dc_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    col1_r      <= col1_nxt;
    left_r      <= left_nxt;
    diag_r      <= diag_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  // Row buffer: one table row of counts.
  lpc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // Checks.
  `LPC_ASSERT_NOW(a_read_only_in_run, vld1_r, state_r == ST_RUN,
                  "read in flight outside the run state")
  `LPC_ASSERT_NOW(a_no_same_cell_rw, issuing_r && vld1_r, col_r != col1_r,
                  "read and write of the same row buffer cell in one cycle")
  `LPC_ASSERT_NOW(a_idle_is_quiet, in_ready, !issuing_r && !vld1_r,
                  "input taken while the table sweep is active")
  `LPC_ASSERT_NEXT(a_fin_loads_result, (state_r == ST_FIN) && out_free,
                   out_valid_r && (state_r == ST_IDLE),
                   "finished count not loaded into the output register")

endmodule

// ----- tb/tb_lattice_path_counter_top.sv -----
// ----------------------------------------------------------------------------
// tb_lattice_path_counter_top
// Sends entry/exit cell pairs to the lattice path counter and checks each
// returned path count against a Delannoy table built in the bench. Covers
// corner cells, empty and reversed queries, straight lines, random queries
// with a bursty sender and a stalling receiver, and a long output hold-off
// that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_lattice_path_counter_top;
  import lpc_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_WORDS    = 36;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 300;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SMALL_SPAN      = 5;
  localparam int FULL_SPAN       = 15;

  // One query in flight and the count it must return.
  typedef struct {
    coord_t sr;
    coord_t sc;
    coord_t er;
    coord_t ec;
    count_t count;
  } path_query_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  coord_t in_start_row;
  coord_t in_start_col;
  coord_t in_end_row;
  coord_t in_end_col;
  logic   out_valid;
  logic   out_ready;
  count_t out_path_count;

  path_query_t owed_counts[$];
  int          mismatch_cnt;
  int          burst_left;
  int          idle_cycles;
  bit          hold_off_req;

  lattice_path_counter_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_row  (in_start_row),
    .in_start_col  (in_start_col),
    .in_end_row    (in_end_row),
    .in_end_col    (in_end_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_path_count(out_path_count)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Delannoy number for the offsets between the two cells; zero when the
  // entry equals the exit or lies past it on either axis.
  function automatic count_t delannoy_count(input coord_t sr, input coord_t sc,
                                            input coord_t er, input coord_t ec);
    logic [63:0] tab [0:15][0:15];
    int          i;
    int          j;
    if (sr > er || sc > ec || (sr == er && sc == ec)) begin
      return '0;
    end
    for (i = 0; i < 16; i++) begin
      for (j = 0; j < 16; j++) begin
        if (i == 0 || j == 0) begin
          tab[i][j] = 64'd1;
        end else begin
          tab[i][j] = tab[i-1][j] + tab[i][j-1] + tab[i-1][j-1];
        end
      end
    end
    return count_t'(tab[er - sr][ec - sc]);
  endfunction

  // Offer one word until accepted, then pace the sender in bursts.
  // Called and returns at a falling edge.
  task automatic send_word(input coord_t sr, input coord_t sc,
                           input coord_t er, input coord_t ec);
    path_query_t q;
    in_valid     <= 1'b1;
    in_start_row <= sr;
    in_start_col <= sc;
    in_end_row   <= er;
    in_end_col   <= ec;
    do @(posedge clk); while (!in_ready);
    q.sr    = sr;
    q.sc    = sc;
    q.er    = er;
    q.ec    = ec;
    q.count = delannoy_count(sr, sc, er, ec);
    owed_counts.push_back(q);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // Send a query whose exit lies at or below and right of its entry.
  task automatic send_forward_query(input int max_span);
    int     dr;
    int     dc;
    coord_t sr;
    coord_t sc;
    dr = $urandom_range(0, max_span);
    dc = $urandom_range(0, max_span);
    sr = coord_t'($urandom_range(0, 15 - dr));
    sc = coord_t'($urandom_range(0, 15 - dc));
    send_word(sr, sc, coord_t'(sr + dr), coord_t'(sc + dc));
  endtask

  // Corner cells, empty and reversed queries, lines and the largest count.
  task automatic test_directed();
    send_word(4'd0,  4'd0,  4'd0,  4'd0);
    send_word(4'd15, 4'd15, 4'd15, 4'd15);
    send_word(4'd7,  4'd3,  4'd7,  4'd3);
    send_word(4'd0,  4'd0,  4'd15, 4'd15);
    send_word(4'd0,  4'd0,  4'd0,  4'd15);
    send_word(4'd0,  4'd0,  4'd15, 4'd0);
    send_word(4'd15, 4'd0,  4'd15, 4'd15);
    send_word(4'd0,  4'd15, 4'd15, 4'd15);
    send_word(4'd0,  4'd0,  4'd1,  4'd1);
    send_word(4'd0,  4'd0,  4'd1,  4'd0);
    send_word(4'd0,  4'd0,  4'd0,  4'd1);
    send_word(4'd8,  4'd0,  4'd7,  4'd15);
    send_word(4'd0,  4'd8,  4'd15, 4'd7);
    send_word(4'd15, 4'd15, 4'd0,  4'd0);
    send_word(4'd15, 4'd0,  4'd0,  4'd15);
    send_word(4'd0,  4'd15, 4'd15, 4'd0);
    send_word(4'd2,  4'd3,  4'd5,  4'd9);
    send_word(4'd0,  4'd0,  4'd15, 4'd14);
    send_word(4'd1,  4'd0,  4'd15, 4'd15);
    send_word(4'd0,  4'd0,  4'd2,  4'd2);
  endtask

  // Mostly small forward queries, some full-size ones, lines, empty
  // queries and fully random words.
  task automatic test_random();
    int     k;
    int     pick;
    coord_t r;
    coord_t c;
    for (k = 0; k < RANDOM_WORDS; k++) begin
      pick = $urandom_range(0, 99);
      r    = coord_t'($urandom_range(0, 15));
      c    = coord_t'($urandom_range(0, 15));
      if (pick < 55) begin
        send_forward_query(SMALL_SPAN);
      end else if (pick < 65) begin
        send_forward_query(FULL_SPAN);
      end else if (pick < 70) begin
        send_word(r, c, r, c);
      end else if (pick < 75) begin
        send_word(r, coord_t'($urandom_range(0, 15)), r, coord_t'($urandom_range(0, 15)));
      end else if (pick < 80) begin
        send_word(coord_t'($urandom_range(0, 15)), c, coord_t'($urandom_range(0, 15)), c);
      end else begin
        send_word(r, c, coord_t'($urandom_range(0, 15)), coord_t'($urandom_range(0, 15)));
      end
    end
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // block fills and drops in_ready.
  task automatic test_output_backpressure();
    int k;
    hold_off_req = 1'b1;
    for (k = 0; k < 8; k++) begin
      send_forward_query(SMALL_SPAN);
    end
  endtask

  // Receiver: periodically pick a new random stall pattern; honor hold-off requests.
  initial begin
    int mode;
    int phase;
    out_ready = 1'b0;
    mode      = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        phase++;
        if (phase % 64 == 0) begin
          mode = $urandom_range(0, 3);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (phase % 5 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each accepted count with the oldest owed one.
  always @(posedge clk) begin
    path_query_t q;
    if (rst_n && out_valid && out_ready) begin
      if (owed_counts.size() == 0) begin
        $display("%0t: unexpected path_count, expected none, actual %0d",
                 $time, out_path_count);
        mismatch_cnt++;
      end else begin
        q = owed_counts.pop_front();
        if (out_path_count !== q.count) begin
          $display("%0t: path_count (%0d,%0d)->(%0d,%0d) expected %0d actual %0d",
                   $time, q.sr, q.sc, q.er, q.ec, q.count, out_path_count);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[lattice_path_counter_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_start_row = '0;
    in_start_col = '0;
    in_end_row   = '0;
    in_end_col   = '0;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    hold_off_req = 1'b0;
    burst_left   = $urandom_range(0, 15);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random();
    test_output_backpressure();
    test_random();

    // Drain: drop valid at once, wait for every owed count, then let the
    // block settle.
    in_valid <= 1'b0;
    wait (owed_counts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[lattice_path_counter_top] OK");
    end else begin
      $display("[lattice_path_counter_top] ERROR");
    end
    $finish;
  end

endmodule
